>>> hw/rtl/transformed_box_bounds_assert.svh
// Assertion macros used by transformed_box_bounds.sv.
`ifndef TRANSFORMED_BOX_BOUNDS_ASSERT_SVH
`define TRANSFORMED_BOX_BOUNDS_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TBB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles.
`define TBB_ASSERT_LAT(label, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/tbb_pkg.sv
package tbb_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int COEF_W          = 16;
    localparam int FRAC_BITS       = 12;
    localparam int TRANS_W         = 32;
    localparam int ROW_W           = 3 * COEF_W;
    localparam int CFG_DATA_W      = ROW_W;
    localparam int CFG_IDX_W       = 3;
    localparam int PIPE_DEPTH      = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X        = 3'd0,
        REG_ROW_Y        = 3'd1,
        REG_ROW_Z        = 3'd2,
        REG_TRANSLATE_X  = 3'd3,
        REG_TRANSLATE_Y  = 3'd4,
        REG_TRANSLATE_Z  = 3'd5,
        REG_BOUNDS_VALID = 3'd6
    } cfg_reg_t;

    localparam logic [ROW_W-1:0] ROW_X_RESET = ROW_W'(4096);
    localparam logic [ROW_W-1:0] ROW_Y_RESET = ROW_W'(4096) << COEF_W;
    localparam logic [ROW_W-1:0] ROW_Z_RESET = ROW_W'(4096) << (2 * COEF_W);

endpackage

>>> hw/rtl/transformed_box_bounds.sv
// Bounds of an affinely transformed axis-aligned box.
// Query channel: raise start with the six box_* corner coordinates (signed
// Q16.16); a word is taken at every rising edge with start high and busy low.
// busy stays low, so a new query may enter on every cycle.
// Result channel: done pulses for one cycle with ok and the out_* extrema,
// once the query has passed the axis register stages; results leave in order.
// The receiver has no way to stall, so results must be taken as they come.
// One query is taken per cycle; each passes through the five register
// stages of each axis unit: products, per-axis min/max pick, two adder stages
// (partial sums, then total), then rounding and saturation.
// Configuration: cfg_wr_en, cfg_index, cfg_data write one register per cycle;
// write only while no query is in flight. Each output axis minimum is the sum
// of the smaller of the two products per input axis plus the translation, the maximum likewise.
// If bounds_valid is clear, ok is 0 and all coordinates are 0.
// Reset clears the pipeline valid bits and loads the identity transform,
// zero translation and bounds_valid low.
module transformed_box_bounds #(
    parameter int COORD_WIDTH = tbb_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [COORD_WIDTH-1:0]         box_min_x,
    input  logic signed [COORD_WIDTH-1:0]         box_min_y,
    input  logic signed [COORD_WIDTH-1:0]         box_min_z,
    input  logic signed [COORD_WIDTH-1:0]         box_max_x,
    input  logic signed [COORD_WIDTH-1:0]         box_max_y,
    input  logic signed [COORD_WIDTH-1:0]         box_max_z,
    input  logic                                  cfg_wr_en,
    input  logic [tbb_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tbb_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                  done,
    output logic                                  ok,
    output logic signed [COORD_WIDTH-1:0]         out_min_x,
    output logic signed [COORD_WIDTH-1:0]         out_min_y,
    output logic signed [COORD_WIDTH-1:0]         out_min_z,
    output logic signed [COORD_WIDTH-1:0]         out_max_x,
    output logic signed [COORD_WIDTH-1:0]         out_max_y,
    output logic signed [COORD_WIDTH-1:0]         out_max_z
);

    `include "transformed_box_bounds_assert.svh"

    localparam int D = tbb_pkg::PIPE_DEPTH;

    logic [tbb_pkg::ROW_W-1:0]          row_x_reg, row_y_reg, row_z_reg;
    logic signed [tbb_pkg::TRANS_W-1:0] tx_reg, ty_reg, tz_reg;
    logic                               bounds_valid_reg;
    logic [D-1:0]                       vld_reg, vld_next;
    logic [D-1:0]                       ok_reg, ok_next;
    logic [2:0][COORD_WIDTH-1:0]        lo, hi;
    logic                               accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign lo     = {box_min_z, box_min_y, box_min_x};
    assign hi     = {box_max_z, box_max_y, box_max_x};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg        <= tbb_pkg::ROW_X_RESET;
            row_y_reg        <= tbb_pkg::ROW_Y_RESET;
            row_z_reg        <= tbb_pkg::ROW_Z_RESET;
            tx_reg           <= '0;
            ty_reg           <= '0;
            tz_reg           <= '0;
            bounds_valid_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (tbb_pkg::cfg_reg_t'(cfg_index))
                tbb_pkg::REG_ROW_X:        row_x_reg <= cfg_data;
                tbb_pkg::REG_ROW_Y:        row_y_reg <= cfg_data;
                tbb_pkg::REG_ROW_Z:        row_z_reg <= cfg_data;
                tbb_pkg::REG_TRANSLATE_X:  tx_reg <= cfg_data[tbb_pkg::TRANS_W-1:0];
                tbb_pkg::REG_TRANSLATE_Y:  ty_reg <= cfg_data[tbb_pkg::TRANS_W-1:0];
                tbb_pkg::REG_TRANSLATE_Z:  tz_reg <= cfg_data[tbb_pkg::TRANS_W-1:0];
                tbb_pkg::REG_BOUNDS_VALID: bounds_valid_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // advance valid and ok with the data
    assign vld_next = {vld_reg[D-2:0], accept};
    assign ok_next  = {ok_reg[D-2:0], bounds_valid_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            ok_reg  <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            ok_reg  <= ok_next;
        end
    end

    tbb_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_x (
        .clk     (clk),
        .row     (row_x_reg),
        .trans   (tx_reg),
        .lo      (lo),
        .hi      (hi),
        .keep    (ok_reg[D-2]),
        .min_out (out_min_x),
        .max_out (out_max_x)
    );

    tbb_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_y (
        .clk     (clk),
        .row     (row_y_reg),
        .trans   (ty_reg),
        .lo      (lo),
        .hi      (hi),
        .keep    (ok_reg[D-2]),
        .min_out (out_min_y),
        .max_out (out_max_y)
    );

    tbb_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_z (
        .clk     (clk),
        .row     (row_z_reg),
        .trans   (tz_reg),
        .lo      (lo),
        .hi      (hi),
        .keep    (ok_reg[D-2]),
        .min_out (out_min_z),
        .max_out (out_max_z)
    );

    assign done = vld_reg[D-1];
    assign ok   = ok_reg[D-1];

    `TBB_ASSERT_LAT(a_latency, accept, tbb_pkg::PIPE_DEPTH, done, "word lost in pipeline")
    `TBB_ASSERT_IMP(a_fail_zero, done && !ok,
        out_min_x == '0 && out_min_y == '0 && out_min_z == '0 &&
        out_max_x == '0 && out_max_y == '0 && out_max_z == '0,
        "failed query returned nonzero bounds")
    `TBB_ASSERT_IMP(a_ordered, done && ok,
        out_min_x <= out_max_x && out_min_y <= out_max_y && out_min_z <= out_max_z,
        "minimum above maximum")

endmodule

>>> hw/rtl/tbb_axis.sv
module tbb_axis #(
    parameter int COORD_WIDTH = tbb_pkg::COORD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic [tbb_pkg::ROW_W-1:0]           row,
    input  logic signed [tbb_pkg::TRANS_W-1:0]  trans,
    input  logic [2:0][COORD_WIDTH-1:0]         lo,
    input  logic [2:0][COORD_WIDTH-1:0]         hi,
    input  logic                                keep,
    output logic signed [COORD_WIDTH-1:0]       min_out,
    output logic signed [COORD_WIDTH-1:0]       max_out
);

    localparam int PW   = COORD_WIDTH + tbb_pkg::COEF_W;
    localparam int TW   = tbb_pkg::TRANS_W + tbb_pkg::FRAC_BITS;
    localparam int SW   = ((PW > TW) ? PW : TW) + 2;
    localparam int QW   = SW - tbb_pkg::FRAC_BITS;
    localparam logic signed [QW-1:0] Q_HI =
        {{(QW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [QW-1:0] Q_LO = ~Q_HI;
    localparam logic signed [SW-1:0] ROUND = SW'(1) <<< (tbb_pkg::FRAC_BITS - 1);

    logic signed [PW-1:0] prod_lo_reg [3];
    logic signed [PW-1:0] prod_hi_reg [3];
    logic signed [PW-1:0] prod_lo_next [3];
    logic signed [PW-1:0] prod_hi_next [3];
    logic signed [PW-1:0] tmin_reg [3];
    logic signed [PW-1:0] tmax_reg [3];
    logic signed [PW-1:0] tmin_next [3];
    logic signed [PW-1:0] tmax_next [3];
    logic signed [SW-1:0] ab_min_reg, ab_max_reg, ct_min_reg, ct_max_reg;
    logic signed [SW-1:0] ab_min_next, ab_max_next, ct_min_next, ct_max_next;
    logic signed [SW-1:0] tot_min_reg, tot_max_reg, tot_min_next, tot_max_next;
    logic signed [SW-1:0] t_ext;
    logic signed [QW-1:0] q_min, q_max, s_min, s_max;
    logic signed [COORD_WIDTH-1:0] min_next, max_next, min_reg, max_reg;
    logic signed [tbb_pkg::COEF_W-1:0] coef [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            coef[k]         = $signed(row[k*tbb_pkg::COEF_W +: tbb_pkg::COEF_W]);
            prod_lo_next[k] = PW'(coef[k]) * PW'($signed(lo[k]));
            prod_hi_next[k] = PW'(coef[k]) * PW'($signed(hi[k]));
            tmin_next[k]    = (prod_lo_reg[k] < prod_hi_reg[k]) ? prod_lo_reg[k]
                                                                 : prod_hi_reg[k];
            tmax_next[k]    = (prod_lo_reg[k] < prod_hi_reg[k]) ? prod_hi_reg[k]
                                                                 : prod_lo_reg[k];
        end
        t_ext        = SW'(trans) <<< tbb_pkg::FRAC_BITS;
        ab_min_next  = SW'(tmin_reg[0]) + SW'(tmin_reg[1]);
        ab_max_next  = SW'(tmax_reg[0]) + SW'(tmax_reg[1]);
        ct_min_next  = SW'(tmin_reg[2]) + t_ext + ROUND;
        ct_max_next  = SW'(tmax_reg[2]) + t_ext + ROUND;
        tot_min_next = ab_min_reg + ct_min_reg;
        tot_max_next = ab_max_reg + ct_max_reg;
        q_min        = QW'(tot_min_reg >>> tbb_pkg::FRAC_BITS);
        q_max        = QW'(tot_max_reg >>> tbb_pkg::FRAC_BITS);
        s_min        = (q_min > Q_HI) ? Q_HI : ((q_min < Q_LO) ? Q_LO : q_min);
        s_max        = (q_max > Q_HI) ? Q_HI : ((q_max < Q_LO) ? Q_LO : q_max);
        min_next     = keep ? s_min[COORD_WIDTH-1:0] : '0;
        max_next     = keep ? s_max[COORD_WIDTH-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        tmin_reg    <= tmin_next;
        tmax_reg    <= tmax_next;
        ab_min_reg  <= ab_min_next;
        ab_max_reg  <= ab_max_next;
        ct_min_reg  <= ct_min_next;
        ct_max_reg  <= ct_max_next;
        tot_min_reg <= tot_min_next;
        tot_max_reg <= tot_max_next;
        min_reg     <= min_next;
        max_reg     <= max_next;
    end

    assign min_out = min_reg;
    assign max_out = max_reg;

endmodule
